// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL that carries concurrent checks.
// Depends on a clk and an active-low rst_n being visible at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `ASSERT_ALWAYS(lbl, (ante) |-> (cons), msg)

`endif

// File: hdl/lpfr_pkg.sv
// Shared types, constants and helpers of the frame reassembler.
// No dependencies; used by the front, queue, back and top level.
package lpfr_pkg;

  localparam int BUF_BYTES   = 2048;
  localparam int BUF_AW      = $clog2(BUF_BYTES);
  localparam int WPOS_W      = $clog2(BUF_BYTES + 1);
  localparam int PKT_LEN_W   = 7;
  localparam int MAGIC_BYTES = 4;
  localparam logic [31:0] MAGIC_WORD = 32'h0100_01a2;
  localparam logic [PKT_LEN_W-1:0] PKT_SIZE_RESET = 7'd64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PACKET  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_NONE       = 3'd0,
    OUT_STARTED    = 3'd1,
    OUT_APPENDED   = 3'd2,
    OUT_BAD_HEADER = 3'd3,
    OUT_BUSY       = 3'd4,
    OUT_OVERRUN    = 3'd5
  } outcome_t;

  // One classified request, as handed from the front to the back.
  typedef struct packed {
    logic                we;
    logic                rd;
    logic [BUF_AW-1:0]   addr;
    logic [7:0]          wdata;
    logic                frame_ready;
    logic [WPOS_W-1:0]   frame_length;
    outcome_t            outcome;
    logic                reboot;
  } lpfr_req_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    magic_byte = MAGIC_WORD[8*idx +: 8];
  endfunction

endpackage

// File: hdl/lpfr_front.sv
// Front end: takes each request, tracks packet and frame state, and
// classifies it into a store access plus status. Depends on lpfr_pkg.
module lpfr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lpfr_pkg::PKT_LEN_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  input  logic [1:0]                    in_command,
  input  logic [7:0]                    in_packet_byte,
  input  logic [lpfr_pkg::PKT_LEN_W-1:0] in_packet_length,
  input  logic                          in_packet_last,
  input  logic [lpfr_pkg::BUF_AW-1:0]   in_read_index,
  input  logic                          q_full,
  output logic                          push,
  output lpfr_pkg::lpfr_req_t           push_req
);

  logic [lpfr_pkg::WPOS_W-1:0]    exp_r, exp_nxt;
  logic [lpfr_pkg::WPOS_W-1:0]    wp_r, wp_nxt;
  logic [lpfr_pkg::WPOS_W-1:0]    pend_r, pend_nxt;
  logic [lpfr_pkg::PKT_LEN_W-1:0] byte_r, byte_nxt;
  logic [lpfr_pkg::PKT_LEN_W-1:0] decl_r, decl_nxt;
  logic [lpfr_pkg::PKT_LEN_W-1:0] stored_r, stored_nxt;
  logic [lpfr_pkg::PKT_LEN_W-1:0] pkt_size_r;
  logic [7:0]                     hdrlo_r, hdrlo_nxt;
  logic                           magic_r, magic_nxt;
  logic                           open_r, open_nxt;
  lpfr_pkg::outcome_t             verd_r, verd_nxt;

  lpfr_pkg::cmd_t                 cmd;
  lpfr_pkg::outcome_t             verd_c, fin;
  logic                           first;
  logic [15:0]                    hdr;
  logic [lpfr_pkg::WPOS_W:0]      span;
  logic [lpfr_pkg::WPOS_W:0]      pos;
  logic [lpfr_pkg::PKT_LEN_W-1:0] off;

  assign push = in_valid && !q_full;
  assign cmd  = lpfr_pkg::cmd_t'(in_command);

  always_comb begin
    exp_nxt    = exp_r;
    wp_nxt     = wp_r;
    pend_nxt   = pend_r;
    byte_nxt   = byte_r;
    decl_nxt   = decl_r;
    stored_nxt = stored_r;
    hdrlo_nxt  = hdrlo_r;
    magic_nxt  = magic_r;
    open_nxt   = open_r;
    verd_c     = verd_r;
    fin        = lpfr_pkg::OUT_NONE;
    first      = (byte_r == '0);
    hdr        = {in_packet_byte, hdrlo_r};
    span       = {1'b0, wp_r} + (lpfr_pkg::WPOS_W + 1)'(in_packet_length);
    pos        = {1'b0, wp_r} + (lpfr_pkg::WPOS_W + 1)'(byte_r);
    off        = byte_r - lpfr_pkg::PKT_LEN_W'(2);
    push_req   = '0;

    unique case (cmd)
      lpfr_pkg::CMD_PACKET: begin
        // Judge a continuation on its first byte, a start on its second.
        if (first) begin
          decl_nxt   = in_packet_length;
          magic_nxt  = 1'b1;
          stored_nxt = '0;
          if (exp_r == '0) begin
            open_nxt = 1'b1;
            verd_c   = (in_packet_length < lpfr_pkg::PKT_LEN_W'(2)) ?
                       lpfr_pkg::OUT_BAD_HEADER : lpfr_pkg::OUT_NONE;
          end else begin
            open_nxt = 1'b0;
            if (wp_r == exp_r)
              verd_c = lpfr_pkg::OUT_BUSY;
            else if (span > {1'b0, exp_r})
              verd_c = lpfr_pkg::OUT_OVERRUN;
            else
              verd_c = lpfr_pkg::OUT_APPENDED;
          end
        end
        if (byte_r >= lpfr_pkg::PKT_LEN_W'(lpfr_pkg::MAGIC_BYTES) ||
            in_packet_byte != lpfr_pkg::magic_byte(byte_r[1:0]))
          magic_nxt = 1'b0;

        if (open_nxt) begin
          if (first) begin
            hdrlo_nxt = in_packet_byte;
          end else if (byte_r == lpfr_pkg::PKT_LEN_W'(1) &&
                       verd_c == lpfr_pkg::OUT_NONE) begin
            pend_nxt = hdr[lpfr_pkg::WPOS_W-1:0];
            if (int'(hdr) <= lpfr_pkg::BUF_BYTES &&
                (decl_nxt == pkt_size_r ||
                 17'(decl_nxt) == 17'(hdr) + 17'd2))
              verd_c = lpfr_pkg::OUT_STARTED;
            else
              verd_c = lpfr_pkg::OUT_BAD_HEADER;
          end else if (byte_r >= lpfr_pkg::PKT_LEN_W'(2) &&
                       verd_c == lpfr_pkg::OUT_STARTED && byte_r < decl_nxt &&
                       int'(off) < lpfr_pkg::BUF_BYTES) begin
            push_req.we    = 1'b1;
            push_req.addr  = lpfr_pkg::BUF_AW'(off);
            push_req.wdata = in_packet_byte;
            stored_nxt     = stored_nxt + lpfr_pkg::PKT_LEN_W'(1);
          end
        end else if (verd_c == lpfr_pkg::OUT_APPENDED && byte_r < decl_nxt) begin
          if (int'(pos) < lpfr_pkg::BUF_BYTES) begin
            push_req.we    = 1'b1;
            push_req.addr  = pos[lpfr_pkg::BUF_AW-1:0];
            push_req.wdata = in_packet_byte;
            stored_nxt     = stored_nxt + lpfr_pkg::PKT_LEN_W'(1);
          end
        end

        verd_nxt = verd_c;
        if (in_packet_last) begin
          if (magic_nxt && byte_r == lpfr_pkg::PKT_LEN_W'(lpfr_pkg::MAGIC_BYTES - 1) &&
              decl_nxt == lpfr_pkg::PKT_LEN_W'(lpfr_pkg::MAGIC_BYTES)) begin
            push_req.reboot = 1'b1;
          end else begin
            fin = (verd_c == lpfr_pkg::OUT_NONE) ? lpfr_pkg::OUT_BAD_HEADER : verd_c;
            if (fin == lpfr_pkg::OUT_STARTED) begin
              exp_nxt = pend_nxt;
              wp_nxt  = lpfr_pkg::WPOS_W'(stored_nxt);
            end else if (fin == lpfr_pkg::OUT_APPENDED) begin
              wp_nxt  = wp_r + lpfr_pkg::WPOS_W'(stored_nxt);
            end
          end
          byte_nxt   = '0;
          magic_nxt  = 1'b1;
          verd_nxt   = lpfr_pkg::OUT_NONE;
          stored_nxt = '0;
          open_nxt   = 1'b0;
        end else begin
          byte_nxt = (byte_r == '1) ? byte_r : byte_r + lpfr_pkg::PKT_LEN_W'(1);
        end
      end
      lpfr_pkg::CMD_READ: begin
        verd_nxt = verd_r;
        if (int'(in_read_index) < lpfr_pkg::BUF_BYTES) begin
          push_req.rd   = 1'b1;
          push_req.addr = in_read_index;
        end
      end
      lpfr_pkg::CMD_RELEASE: begin
        // Empty the buffer and drop any packet in progress.
        exp_nxt    = '0;
        wp_nxt     = '0;
        byte_nxt   = '0;
        magic_nxt  = 1'b1;
        verd_nxt   = lpfr_pkg::OUT_NONE;
        stored_nxt = '0;
        open_nxt   = 1'b0;
      end
      default: begin
        verd_nxt = verd_r;
      end
    endcase

    push_req.outcome      = fin;
    push_req.frame_ready  = (exp_nxt != '0) && (wp_nxt == exp_nxt);
    push_req.frame_length = push_req.frame_ready ? exp_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r    <= '0;
      wp_r     <= '0;
      pend_r   <= '0;
      byte_r   <= '0;
      decl_r   <= '0;
      stored_r <= '0;
      hdrlo_r  <= '0;
      magic_r  <= 1'b1;
      open_r   <= 1'b0;
      verd_r   <= lpfr_pkg::OUT_NONE;
    end else if (push) begin
      exp_r    <= exp_nxt;
      wp_r     <= wp_nxt;
      pend_r   <= pend_nxt;
      byte_r   <= byte_nxt;
      decl_r   <= decl_nxt;
      stored_r <= stored_nxt;
      hdrlo_r  <= hdrlo_nxt;
      magic_r  <= magic_nxt;
      open_r   <= open_nxt;
      verd_r   <= verd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_size_r <= lpfr_pkg::PKT_SIZE_RESET;
    end else if (cfg_wr_en) begin
      pkt_size_r <= cfg_wr_data;
    end
  end

endmodule

// File: hdl/lpfr_queue.sv
// Short request queue that decouples the front end from the store side.
// Depends on lpfr_pkg for the request type and depth.
module lpfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpfr_pkg::lpfr_req_t push_req,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output lpfr_pkg::lpfr_req_t pop_req
);

  lpfr_pkg::lpfr_req_t              slot_r [lpfr_pkg::QUEUE_DEPTH];
  logic [lpfr_pkg::QUEUE_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [lpfr_pkg::QUEUE_CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == lpfr_pkg::QUEUE_CW'(lpfr_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_req   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)
      count_nxt = count_r + lpfr_pkg::QUEUE_CW'(1);
    else if (pop && !push)
      count_nxt = count_r - lpfr_pkg::QUEUE_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= wr_ptr_r + lpfr_pkg::QUEUE_AW'(1);
      if (pop)
        rd_ptr_r <= rd_ptr_r + lpfr_pkg::QUEUE_AW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      slot_r[wr_ptr_r] <= push_req;
  end

endmodule

// File: hdl/lpfr_back.sv
// Back end: carries out store writes and reads in order and holds the
// result register. Depends on lpfr_pkg.
module lpfr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  lpfr_pkg::lpfr_req_t           q_req,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_frame_ready,
  output logic [lpfr_pkg::WPOS_W-1:0]   out_frame_length,
  output logic [7:0]                    out_read_data,
  output logic [2:0]                    out_packet_outcome,
  output logic                          out_reboot_request
);

  logic [7:0]                  store_r [lpfr_pkg::BUF_BYTES];
  logic [7:0]                  rdata_r;
  logic                        res_valid_r;
  logic                        res_rd_r;
  logic                        res_ready_r;
  logic [lpfr_pkg::WPOS_W-1:0] res_len_r;
  lpfr_pkg::outcome_t          res_outcome_r;
  logic                        res_reboot_r;

  // Advance whenever the result register is empty or being taken.
  assign q_pop = q_valid && (!res_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (q_pop && q_req.we)
      store_r[q_req.addr] <= q_req.wdata;
    if (q_pop && q_req.rd)
      rdata_r <= store_r[q_req.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (q_pop) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_rd_r      <= q_req.rd;
      res_ready_r   <= q_req.frame_ready;
      res_len_r     <= q_req.frame_length;
      res_outcome_r <= q_req.outcome;
      res_reboot_r  <= q_req.reboot;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_frame_ready    = res_ready_r;
  assign out_frame_length   = res_len_r;
  assign out_read_data      = res_rd_r ? rdata_r : 8'd0;
  assign out_packet_outcome = res_outcome_r;
  assign out_reboot_request = res_reboot_r;

endmodule

// File: hdl/length_prefixed_frame_reassembler.sv
// Frame reassembler for USB bulk packets: one packet byte, read or release
// request per cycle while in_stall is low, one result per request, delivered
// in order. The front end classifies the request and updates packet/frame
// state at the accepting edge, writing it into a four-entry queue; the back
// end then pops it, makes the single access to the 2048-byte store and
// loads the result register. Sustained rate is one request per cycle while
// the output is not stalled, set by that one store access per request. A
// held result stalls the input once the queue is full. The store has no
// reset; reading a location never written returns garbage.
// Depends on lpfr_pkg, lpfr_front, lpfr_queue, lpfr_back, assert_macros.svh.
`include "assert_macros.svh"

module length_prefixed_frame_reassembler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lpfr_pkg::PKT_LEN_W-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [7:0]                     in_packet_byte,
  input  logic [lpfr_pkg::PKT_LEN_W-1:0] in_packet_length,
  input  logic                           in_packet_last,
  input  logic [lpfr_pkg::BUF_AW-1:0]    in_read_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_frame_ready,
  output logic [lpfr_pkg::WPOS_W-1:0]    out_frame_length,
  output logic [7:0]                     out_read_data,
  output logic [2:0]                     out_packet_outcome,
  output logic                           out_reboot_request
);

  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  lpfr_pkg::lpfr_req_t push_req;
  lpfr_pkg::lpfr_req_t pop_req;

  assign in_stall = q_full;

  lpfr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_command       (in_command),
    .in_packet_byte   (in_packet_byte),
    .in_packet_length (in_packet_length),
    .in_packet_last   (in_packet_last),
    .in_read_index    (in_read_index),
    .q_full           (q_full),
    .push             (q_push),
    .push_req         (push_req)
  );

  lpfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (push_req),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_req   (pop_req)
  );

  lpfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_req              (pop_req),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_ready    (out_frame_ready),
    .out_frame_length   (out_frame_length),
    .out_read_data      (out_read_data),
    .out_packet_outcome (out_packet_outcome),
    .out_reboot_request (out_reboot_request)
  );

  `ASSERT_IMPLIES(a_reboot_no_outcome, out_valid && out_reboot_request,
                  out_packet_outcome == lpfr_pkg::OUT_NONE,
                  "reboot request carried a packet outcome")
  `ASSERT_IMPLIES(a_ready_has_length, out_valid && out_frame_ready,
                  out_frame_length != '0, "ready frame reported with zero length")
  `ASSERT_IMPLIES(a_idle_no_length, out_valid && !out_frame_ready,
                  out_frame_length == '0, "length shown without a ready frame")
  `ASSERT_IMPLIES(a_pop_needs_entry, q_pop, q_valid, "queue popped while empty")

endmodule
